>>> sv/cpu8_pkg.sv
`timescale 1ns / 1ps
package cpu8_pkg;

    typedef enum logic [5:0] {
        OP_LDA = 6'd0, OP_LDX = 6'd1, OP_LDY = 6'd2, OP_STA = 6'd3, OP_STX = 6'd4,
        OP_STY = 6'd5, OP_TAX = 6'd6, OP_TAY = 6'd7, OP_TXA = 6'd8, OP_TXY = 6'd9,
        OP_TXSP = 6'd10, OP_TXSS = 6'd11, OP_TYA = 6'd12, OP_TYX = 6'd13,
        OP_TYDS = 6'd14, OP_TYES = 6'd15, OP_TSPX = 6'd16, OP_TSSX = 6'd17,
        OP_TDSY = 6'd18, OP_TESY = 6'd19, OP_INA = 6'd20, OP_INX = 6'd21,
        OP_INY = 6'd22, OP_INC = 6'd23, OP_DEA = 6'd24, OP_DEX = 6'd25,
        OP_DEY = 6'd26, OP_DEC = 6'd27, OP_ADC = 6'd28, OP_SBB = 6'd29,
        OP_MUL = 6'd30, OP_DIV = 6'd31, OP_MOD = 6'd32, OP_AND = 6'd33,
        OP_OR = 6'd34, OP_XOR = 6'd35, OP_SHLA = 6'd36, OP_SHL = 6'd37,
        OP_SHRA = 6'd38, OP_SHR = 6'd39, OP_ROLA = 6'd40, OP_ROL = 6'd41,
        OP_RORA = 6'd42, OP_ROR = 6'd43, OP_CMP = 6'd44, OP_CPX = 6'd45,
        OP_CPY = 6'd46, OP_JMP = 6'd47, OP_JC = 6'd48, OP_JNC = 6'd49,
        OP_JE = 6'd50, OP_JNE = 6'd51, OP_JS = 6'd52, OP_JNS = 6'd53,
        OP_JO = 6'd54, OP_JNO = 6'd55, OP_JA = 6'd56, OP_JNA = 6'd57,
        OP_JL = 6'd58, OP_JGE = 6'd59, OP_JG = 6'd60, OP_JNG = 6'd61,
        OP_LOOP = 6'd62, OP_CALL = 6'd63
    } t_op;

    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_S = 2;
    localparam int unsigned FLAG_V = 3;
    localparam int unsigned DIV_STEPS = 8;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_DIV, ST_OUT1, ST_OUT2
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic push_second;
    } t_cmd;

    typedef struct packed {
        logic is_div;
        logic is_call;
        logic div_done;
    } t_status;

endpackage

>>> sv/cpu8_execute_unit_top.sv
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in      | input     | i_valid / o_stall  | req_type, operand, effective_address,
//         |           |                    | memory_value, next_pc
// out     | output    | o_valid / i_stall  | write_enable .. flags_out, last_result
// The result is presented once the execute state has registered it; divide and modulo
// first pass a setup step, eight restoring divider steps and an execute step.
// Call presents its second result once the first is taken.
// One item at a time: o_stall is high from accept until the last result is taken.
// Synchronous active-low reset clears the state, the register file, the flags,
// the write enable and the divide counter.
// Results hold steady while i_stall is high.
module cpu8_execute_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_req_type,
    input  logic [7:0]  i_operand,
    input  logic [15:0] i_effective_address,
    input  logic [7:0]  i_memory_value,
    input  logic [15:0] i_next_pc,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_write_enable,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_data,
    output logic        o_last_result,
    output logic [15:0] o_new_pc,
    output logic        o_branch_taken,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_x_out,
    output logic [7:0]  o_y_out,
    output logic [3:0]  o_flags_out
);

    cpu8_pkg::t_cmd    cmd;
    cpu8_pkg::t_status status;

    cpu8_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_last_result,
        .i_status(status), .o_cmd(cmd)
    );

    cpu8_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status),
        .i_req_type, .i_operand, .i_effective_address, .i_memory_value, .i_next_pc,
        .o_write_enable, .o_write_address, .o_write_data, .o_new_pc, .o_branch_taken,
        .o_acc_out, .o_x_out, .o_y_out, .o_flags_out
    );

endmodule

>>> sv/cpu8_datapath.sv
`timescale 1ns / 1ps
module cpu8_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpu8_pkg::t_cmd      i_cmd,
    output cpu8_pkg::t_status   o_status,
    input  logic [5:0]          i_req_type,
    input  logic [7:0]          i_operand,
    input  logic [15:0]         i_effective_address,
    input  logic [7:0]          i_memory_value,
    input  logic [15:0]         i_next_pc,
    output logic                o_write_enable,
    output logic [15:0]         o_write_address,
    output logic [7:0]          o_write_data,
    output logic [15:0]         o_new_pc,
    output logic                o_branch_taken,
    output logic [7:0]          o_acc_out,
    output logic [7:0]          o_x_out,
    output logic [7:0]          o_y_out,
    output logic [3:0]          o_flags_out
);

    cpu8_pkg::t_op r_op;
    logic [7:0]  r_opd, r_mem;
    logic [15:0] r_ea, r_npc;
    logic [7:0]  r_a, r_x, r_y, r_sp, r_ss, r_ds, r_es;
    logic [3:0]  r_f;
    logic [7:0]  n_a, n_x, n_y, n_sp, n_ss, n_ds, n_es;
    logic [3:0]  n_f;
    logic        r_we, n_we, r_tk, n_tk;
    logic [15:0] r_wa, n_wa, r_pc, n_pc;
    logic [7:0]  r_wd, n_wd, r_wd2;
    logic [15:0] r_wa2;
    logic [7:0]  r_quo, r_rem, r_dvs;
    logic [3:0]  r_cnt;

    logic [8:0]  sum, dif, prod_hi;
    logic [15:0] prod;
    logic [7:0]  v, sub_a;
    logic        cin, cond, setzs, sub_cin;
    logic [8:0]  trial, rem_sh;

    assign cin  = r_f[cpu8_pkg::FLAG_C];
    assign prod = r_a * r_opd;
    assign prod_hi = {1'b0, prod[15:8]};

    assign rem_sh = {r_rem, r_quo[7]};
    assign trial  = rem_sh - {1'b0, r_dvs};

    always_comb begin
        sub_a = r_a;
        sub_cin = cin;
        if (r_op == cpu8_pkg::OP_CPX) sub_a = r_x;
        if (r_op == cpu8_pkg::OP_CPY) sub_a = r_y;
        if (r_op == cpu8_pkg::OP_CMP || r_op == cpu8_pkg::OP_CPX
            || r_op == cpu8_pkg::OP_CPY) sub_cin = 1'b0;
    end
    assign sum = {1'b0, r_a} + {1'b0, r_opd} + {8'd0, cin};
    assign dif = {1'b0, sub_a} - {1'b0, r_opd} - {8'd0, sub_cin};

    always_comb begin
        n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp;
        n_ss = r_ss; n_ds = r_ds; n_es = r_es; n_f = r_f;
        n_we = 1'b0; n_wa = '0; n_wd = '0;
        v = 8'd0; setzs = 1'b1; cond = 1'b0;
        unique case (r_op)
            cpu8_pkg::OP_LDA: begin v = r_opd; n_a = v; end
            cpu8_pkg::OP_LDX: begin v = r_opd; n_x = v; end
            cpu8_pkg::OP_LDY: begin v = r_opd; n_y = v; end
            cpu8_pkg::OP_STA: begin setzs = 1'b0; n_we = 1'b1; n_wa = r_ea; n_wd = r_a; end
            cpu8_pkg::OP_STX: begin setzs = 1'b0; n_we = 1'b1; n_wa = r_ea; n_wd = r_x; end
            cpu8_pkg::OP_STY: begin setzs = 1'b0; n_we = 1'b1; n_wa = r_ea; n_wd = r_y; end
            cpu8_pkg::OP_TAX: begin v = r_x; n_a = v; end
            cpu8_pkg::OP_TAY: begin v = r_y; n_a = v; end
            cpu8_pkg::OP_TXA: begin v = r_a; n_x = v; end
            cpu8_pkg::OP_TXY: begin v = r_y; n_x = v; end
            cpu8_pkg::OP_TXSP: begin v = r_sp; n_x = v; end
            cpu8_pkg::OP_TXSS: begin v = r_ss; n_x = v; end
            cpu8_pkg::OP_TYA: begin v = r_a; n_y = v; end
            cpu8_pkg::OP_TYX: begin v = r_x; n_y = v; end
            cpu8_pkg::OP_TYDS: begin v = r_ds; n_y = v; end
            cpu8_pkg::OP_TYES: begin v = r_es; n_y = v; end
            cpu8_pkg::OP_TSPX: begin v = r_x; n_sp = v; end
            cpu8_pkg::OP_TSSX: begin v = r_x; n_ss = v; end
            cpu8_pkg::OP_TDSY: begin v = r_y; n_ds = v; end
            cpu8_pkg::OP_TESY: begin v = r_y; n_es = v; end
            cpu8_pkg::OP_INA: begin v = r_a + 8'd1; n_a = v; end
            cpu8_pkg::OP_INX: begin v = r_x + 8'd1; n_x = v; end
            cpu8_pkg::OP_INY: begin v = r_y + 8'd1; n_y = v; end
            cpu8_pkg::OP_INC: begin
                v = r_mem + 8'd1; n_we = 1'b1; n_wa = r_ea; n_wd = v;
            end
            cpu8_pkg::OP_DEA: begin v = r_a - 8'd1; n_a = v; end
            cpu8_pkg::OP_DEX: begin v = r_x - 8'd1; n_x = v; end
            cpu8_pkg::OP_DEY: begin v = r_y - 8'd1; n_y = v; end
            cpu8_pkg::OP_DEC: begin
                v = r_mem - 8'd1; n_we = 1'b1; n_wa = r_ea; n_wd = v;
            end
            cpu8_pkg::OP_ADC: begin
                v = sum[7:0]; n_a = v;
                n_f[cpu8_pkg::FLAG_C] = sum[8];
                n_f[cpu8_pkg::FLAG_V] = (r_a[7] == r_opd[7]) && (v[7] != r_a[7]);
            end
            cpu8_pkg::OP_SBB, cpu8_pkg::OP_CMP, cpu8_pkg::OP_CPX,
            cpu8_pkg::OP_CPY: begin
                v = dif[7:0];
                if (r_op == cpu8_pkg::OP_SBB) n_a = v;
                n_f[cpu8_pkg::FLAG_C] = dif[8];
                n_f[cpu8_pkg::FLAG_V] = (sub_a[7] != r_opd[7]) && (v[7] != sub_a[7]);
            end
            cpu8_pkg::OP_MUL: begin
                v = prod[7:0]; n_a = v;
                n_f[cpu8_pkg::FLAG_C] = (prod_hi != 9'd0);
            end
            cpu8_pkg::OP_DIV: begin
                v = (r_dvs == 8'd0) ? 8'hFF : r_quo; n_a = v;
            end
            cpu8_pkg::OP_MOD: begin
                v = (r_dvs == 8'd0) ? r_a : r_rem; n_a = v;
            end
            cpu8_pkg::OP_AND: begin v = r_a & r_opd; n_a = v; end
            cpu8_pkg::OP_OR:  begin v = r_a | r_opd; n_a = v; end
            cpu8_pkg::OP_XOR: begin v = r_a ^ r_opd; n_a = v; end
            cpu8_pkg::OP_SHLA: begin
                n_f[cpu8_pkg::FLAG_C] = r_a[7]; v = {r_a[6:0], 1'b0}; n_a = v;
            end
            cpu8_pkg::OP_SHL: begin
                n_f[cpu8_pkg::FLAG_C] = r_mem[7]; v = {r_mem[6:0], 1'b0};
                n_we = 1'b1; n_wa = r_ea; n_wd = v;
            end
            cpu8_pkg::OP_SHRA: begin
                n_f[cpu8_pkg::FLAG_C] = r_a[0]; v = {1'b0, r_a[7:1]}; n_a = v;
            end
            cpu8_pkg::OP_SHR: begin
                n_f[cpu8_pkg::FLAG_C] = r_mem[0]; v = {1'b0, r_mem[7:1]};
                n_we = 1'b1; n_wa = r_ea; n_wd = v;
            end
            cpu8_pkg::OP_ROLA: begin
                n_f[cpu8_pkg::FLAG_C] = r_a[7]; v = {r_a[6:0], cin}; n_a = v;
            end
            cpu8_pkg::OP_ROL: begin
                n_f[cpu8_pkg::FLAG_C] = r_mem[7]; v = {r_mem[6:0], cin};
                n_we = 1'b1; n_wa = r_ea; n_wd = v;
            end
            cpu8_pkg::OP_RORA: begin
                n_f[cpu8_pkg::FLAG_C] = r_a[0]; v = {cin, r_a[7:1]}; n_a = v;
            end
            cpu8_pkg::OP_ROR: begin
                n_f[cpu8_pkg::FLAG_C] = r_mem[0]; v = {cin, r_mem[7:1]};
                n_we = 1'b1; n_wa = r_ea; n_wd = v;
            end
            cpu8_pkg::OP_JMP: begin setzs = 1'b0; cond = 1'b1; end
            cpu8_pkg::OP_JC:  begin setzs = 1'b0; cond = r_f[0]; end
            cpu8_pkg::OP_JNC: begin setzs = 1'b0; cond = !r_f[0]; end
            cpu8_pkg::OP_JE:  begin setzs = 1'b0; cond = r_f[1]; end
            cpu8_pkg::OP_JNE: begin setzs = 1'b0; cond = !r_f[1]; end
            cpu8_pkg::OP_JS:  begin setzs = 1'b0; cond = r_f[2]; end
            cpu8_pkg::OP_JNS: begin setzs = 1'b0; cond = !r_f[2]; end
            cpu8_pkg::OP_JO:  begin setzs = 1'b0; cond = r_f[3]; end
            cpu8_pkg::OP_JNO: begin setzs = 1'b0; cond = !r_f[3]; end
            cpu8_pkg::OP_JA:  begin setzs = 1'b0; cond = !r_f[0] && !r_f[1]; end
            cpu8_pkg::OP_JNA: begin setzs = 1'b0; cond = r_f[0] || r_f[1]; end
            cpu8_pkg::OP_JL:  begin setzs = 1'b0; cond = r_f[2] != r_f[3]; end
            cpu8_pkg::OP_JGE: begin setzs = 1'b0; cond = r_f[2] == r_f[3]; end
            cpu8_pkg::OP_JG:  begin
                setzs = 1'b0; cond = !r_f[1] && (r_f[2] == r_f[3]);
            end
            cpu8_pkg::OP_JNG: begin
                setzs = 1'b0; cond = r_f[1] || (r_f[2] != r_f[3]);
            end
            cpu8_pkg::OP_LOOP: begin
                setzs = 1'b0; cond = (r_y != 8'd0);
                if (cond) n_y = r_y - 8'd1;
            end
            cpu8_pkg::OP_CALL: begin
                setzs = 1'b0; cond = 1'b1;
                n_we = 1'b1; n_wa = {r_ss, r_sp}; n_wd = r_npc[15:8];
                n_sp = r_sp - 8'd2;
            end
            default: setzs = 1'b0;
        endcase
        if (setzs) begin
            n_f[cpu8_pkg::FLAG_Z] = (v == 8'd0);
            n_f[cpu8_pkg::FLAG_S] = v[7];
        end
        n_tk = cond;
        n_pc = cond ? r_ea : r_npc;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= cpu8_pkg::t_op'(i_req_type);
            r_opd <= i_operand;
            r_ea  <= i_effective_address;
            r_mem <= i_memory_value;
            r_npc <= i_next_pc;
        end
        if (i_cmd.div_start) begin
            r_quo <= r_a;
            r_rem <= 8'd0;
            r_dvs <= r_opd;
        end else if (i_cmd.div_step) begin
            if (!trial[8]) begin
                r_rem <= trial[7:0];
                r_quo <= {r_quo[6:0], 1'b1};
            end else begin
                r_rem <= rem_sh[7:0];
                r_quo <= {r_quo[6:0], 1'b0};
            end
        end
        if (i_cmd.exec) begin
            r_wa  <= n_wa;
            r_wd  <= n_wd;
            r_wa2 <= {r_ss, r_sp - 8'd1};
            r_wd2 <= r_npc[7:0];
            r_pc  <= n_pc;
            r_tk  <= n_tk;
        end else if (i_cmd.push_second) begin
            r_wa <= r_wa2;
            r_wd <= r_wd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0; r_x <= '0; r_y <= '0; r_sp <= '0;
            r_ss <= '0; r_ds <= '0; r_es <= '0; r_f <= '0;
            r_we <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_a <= n_a; r_x <= n_x; r_y <= n_y; r_sp <= n_sp;
                r_ss <= n_ss; r_ds <= n_ds; r_es <= n_es; r_f <= n_f;
                r_we <= n_we;
            end
            if (i_cmd.div_start) r_cnt <= 4'(cpu8_pkg::DIV_STEPS);
            else if (i_cmd.div_step) r_cnt <= r_cnt - 4'd1;
        end
    end

    assign o_status.is_div   = (r_op == cpu8_pkg::OP_DIV) || (r_op == cpu8_pkg::OP_MOD);
    assign o_status.is_call  = (r_op == cpu8_pkg::OP_CALL);
    assign o_status.div_done = (r_cnt == 4'd0);

    assign o_write_enable  = r_we;
    assign o_write_address = r_wa;
    assign o_write_data    = r_wd;
    assign o_new_pc        = r_pc;
    assign o_branch_taken  = r_tk;
    assign o_acc_out       = r_a;
    assign o_x_out         = r_x;
    assign o_y_out         = r_y;
    assign o_flags_out     = r_f;

endmodule

>>> sv/cpu8_ctrl.sv
`timescale 1ns / 1ps
module cpu8_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_last_result,
    input  cpu8_pkg::t_status   i_status,
    output cpu8_pkg::t_cmd      o_cmd
);

    cpu8_pkg::t_state r_state, n_state;
    logic accept, out_take;

    assign accept   = (r_state == cpu8_pkg::ST_IDLE) && i_valid;
    assign out_take = o_valid && !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cpu8_pkg::ST_IDLE: if (i_valid) n_state = cpu8_pkg::ST_EXEC;
            cpu8_pkg::ST_EXEC: begin
                if (i_status.is_div) n_state = cpu8_pkg::ST_DIV;
                else n_state = cpu8_pkg::ST_OUT1;
            end
            cpu8_pkg::ST_DIV: if (i_status.div_done) n_state = cpu8_pkg::ST_OUT1;
            cpu8_pkg::ST_OUT1: begin
                if (out_take)
                    n_state = i_status.is_call ? cpu8_pkg::ST_OUT2 : cpu8_pkg::ST_IDLE;
            end
            cpu8_pkg::ST_OUT2: if (out_take) n_state = cpu8_pkg::ST_IDLE;
            default: n_state = cpu8_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            cpu8_pkg::ST_IDLE: o_cmd.load = i_valid;
            cpu8_pkg::ST_EXEC: begin
                o_cmd.div_start = i_status.is_div;
                o_cmd.exec      = !i_status.is_div;
            end
            cpu8_pkg::ST_DIV: begin
                o_cmd.div_step = !i_status.div_done;
                o_cmd.exec     = i_status.div_done;
            end
            cpu8_pkg::ST_OUT1: o_cmd.push_second = out_take && i_status.is_call;
            default: ;
        endcase
    end

    assign o_stall       = (r_state != cpu8_pkg::ST_IDLE);
    assign o_valid       = (r_state == cpu8_pkg::ST_OUT1) || (r_state == cpu8_pkg::ST_OUT2);
    assign o_last_result = (r_state == cpu8_pkg::ST_OUT2) ||
                           ((r_state == cpu8_pkg::ST_OUT1) && !i_status.is_call);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= cpu8_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == cpu8_pkg::ST_EXEC)) else $error("accept not followed by exec");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped under stall");
    a_call_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpu8_pkg::ST_OUT2) |-> i_status.is_call) else $error("second item not call");
    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_cmd.exec) else $error("double exec");

endmodule

>>> tb/cpu8_execute_unit_top_tb.sv
`timescale 1ns / 1ps
module cpu8_execute_unit_top_tb;

    typedef struct packed {
        cpu8_pkg::t_op op;
        logic [7:0]    operand;
        logic [15:0]   ea;
        logic [7:0]    mem;
        logic [15:0]   npc;
    } t_instr;

    typedef struct packed {
        logic        we;
        logic [15:0] waddr;
        logic [7:0]  wdata;
        logic        last;
        logic [15:0] new_pc;
        logic        taken;
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [3:0]  flags;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [5:0]  i_req_type;
    logic [7:0]  i_operand;
    logic [15:0] i_effective_address;
    logic [7:0]  i_memory_value;
    logic [15:0] i_next_pc;
    logic        o_valid;
    logic        i_stall;
    logic        o_write_enable;
    logic [15:0] o_write_address;
    logic [7:0]  o_write_data;
    logic        o_last_result;
    logic [15:0] o_new_pc;
    logic        o_branch_taken;
    logic [7:0]  o_acc_out;
    logic [7:0]  o_x_out;
    logic [7:0]  o_y_out;
    logic [3:0]  o_flags_out;

    cpu8_execute_unit_top i_dut (.*);

    t_instr   pending_instrs[$];
    t_outcome expected_outcomes[$];
    int       mismatches;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_req;
    bit       hold_off;
    bit       took;

    logic [7:0] reg_a, reg_x, reg_y, reg_sp, reg_ss, reg_ds, reg_es;
    logic [3:0] reg_flags;

    initial i_clk = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [7:0] set_zs(logic [7:0] v);
        reg_flags[cpu8_pkg::FLAG_Z] = (v == 8'd0);
        reg_flags[cpu8_pkg::FLAG_S] = v[7];
        return v;
    endfunction

    function automatic logic [7:0] sub_flags(logic [7:0] a, logic [7:0] b, logic cin);
        logic [7:0] r;
        r = a - b - cin;
        reg_flags[cpu8_pkg::FLAG_C] = ({1'b0, a} < {1'b0, b} + cin);
        reg_flags[cpu8_pkg::FLAG_V] = (a[7] && !b[7] && !r[7]) || (!a[7] && b[7] && r[7]);
        return set_zs(r);
    endfunction

    task automatic execute_instr(t_instr it);
        logic        cin, we, cond, c, z, s, v;
        logic [15:0] wa, wa2, npc;
        logic [7:0]  wd, wd2, t;
        logic [8:0]  wide;
        logic [15:0] prod;
        t_outcome    res;
        int          n;
        cin = reg_flags[cpu8_pkg::FLAG_C];
        c = reg_flags[cpu8_pkg::FLAG_C];
        z = reg_flags[cpu8_pkg::FLAG_Z];
        s = reg_flags[cpu8_pkg::FLAG_S];
        v = reg_flags[cpu8_pkg::FLAG_V];
        we = 1'b0;
        cond = 1'b0;
        wa = '0;
        wa2 = '0;
        wd = '0;
        wd2 = '0;
        npc = it.npc;
        n = 1;
        case (it.op)
            cpu8_pkg::OP_LDA: reg_a = set_zs(it.operand);
            cpu8_pkg::OP_LDX: reg_x = set_zs(it.operand);
            cpu8_pkg::OP_LDY: reg_y = set_zs(it.operand);
            cpu8_pkg::OP_STA: begin we = 1; wa = it.ea; wd = reg_a; end
            cpu8_pkg::OP_STX: begin we = 1; wa = it.ea; wd = reg_x; end
            cpu8_pkg::OP_STY: begin we = 1; wa = it.ea; wd = reg_y; end
            cpu8_pkg::OP_TAX: reg_a = set_zs(reg_x);
            cpu8_pkg::OP_TAY: reg_a = set_zs(reg_y);
            cpu8_pkg::OP_TXA: reg_x = set_zs(reg_a);
            cpu8_pkg::OP_TXY: reg_x = set_zs(reg_y);
            cpu8_pkg::OP_TXSP: reg_x = set_zs(reg_sp);
            cpu8_pkg::OP_TXSS: reg_x = set_zs(reg_ss);
            cpu8_pkg::OP_TYA: reg_y = set_zs(reg_a);
            cpu8_pkg::OP_TYX: reg_y = set_zs(reg_x);
            cpu8_pkg::OP_TYDS: reg_y = set_zs(reg_ds);
            cpu8_pkg::OP_TYES: reg_y = set_zs(reg_es);
            cpu8_pkg::OP_TSPX: reg_sp = set_zs(reg_x);
            cpu8_pkg::OP_TSSX: reg_ss = set_zs(reg_x);
            cpu8_pkg::OP_TDSY: reg_ds = set_zs(reg_y);
            cpu8_pkg::OP_TESY: reg_es = set_zs(reg_y);
            cpu8_pkg::OP_INA: reg_a = set_zs(reg_a + 8'd1);
            cpu8_pkg::OP_INX: reg_x = set_zs(reg_x + 8'd1);
            cpu8_pkg::OP_INY: reg_y = set_zs(reg_y + 8'd1);
            cpu8_pkg::OP_INC: begin we = 1; wa = it.ea; wd = set_zs(it.mem + 8'd1); end
            cpu8_pkg::OP_DEA: reg_a = set_zs(reg_a - 8'd1);
            cpu8_pkg::OP_DEX: reg_x = set_zs(reg_x - 8'd1);
            cpu8_pkg::OP_DEY: reg_y = set_zs(reg_y - 8'd1);
            cpu8_pkg::OP_DEC: begin we = 1; wa = it.ea; wd = set_zs(it.mem - 8'd1); end
            cpu8_pkg::OP_ADC: begin
                wide = {1'b0, reg_a} + {1'b0, it.operand} + cin;
                reg_flags[cpu8_pkg::FLAG_C] = wide[8];
                reg_flags[cpu8_pkg::FLAG_V] = (reg_a[7] == it.operand[7]) &&
                                              (wide[7] != reg_a[7]);
                reg_a = set_zs(wide[7:0]);
            end
            cpu8_pkg::OP_SBB: reg_a = sub_flags(reg_a, it.operand, cin);
            cpu8_pkg::OP_MUL: begin
                prod = reg_a * it.operand;
                reg_flags[cpu8_pkg::FLAG_C] = (prod > 16'd255);
                reg_a = set_zs(prod[7:0]);
            end
            cpu8_pkg::OP_DIV: reg_a = set_zs(it.operand != 0 ? reg_a / it.operand : 8'd255);
            cpu8_pkg::OP_MOD: reg_a = set_zs(it.operand != 0 ? reg_a % it.operand : reg_a);
            cpu8_pkg::OP_AND: reg_a = set_zs(reg_a & it.operand);
            cpu8_pkg::OP_OR: reg_a = set_zs(reg_a | it.operand);
            cpu8_pkg::OP_XOR: reg_a = set_zs(reg_a ^ it.operand);
            cpu8_pkg::OP_SHLA: begin
                reg_flags[cpu8_pkg::FLAG_C] = reg_a[7];
                reg_a = set_zs(reg_a << 1);
            end
            cpu8_pkg::OP_SHL: begin
                reg_flags[cpu8_pkg::FLAG_C] = it.mem[7];
                we = 1; wa = it.ea; wd = set_zs(it.mem << 1);
            end
            cpu8_pkg::OP_SHRA: begin
                reg_flags[cpu8_pkg::FLAG_C] = reg_a[0];
                reg_a = set_zs(reg_a >> 1);
            end
            cpu8_pkg::OP_SHR: begin
                reg_flags[cpu8_pkg::FLAG_C] = it.mem[0];
                we = 1; wa = it.ea; wd = set_zs(it.mem >> 1);
            end
            cpu8_pkg::OP_ROLA: begin
                t = {reg_a[6:0], cin};
                reg_flags[cpu8_pkg::FLAG_C] = reg_a[7];
                reg_a = set_zs(t);
            end
            cpu8_pkg::OP_ROL: begin
                t = {it.mem[6:0], cin};
                reg_flags[cpu8_pkg::FLAG_C] = it.mem[7];
                we = 1; wa = it.ea; wd = set_zs(t);
            end
            cpu8_pkg::OP_RORA: begin
                t = {cin, reg_a[7:1]};
                reg_flags[cpu8_pkg::FLAG_C] = reg_a[0];
                reg_a = set_zs(t);
            end
            cpu8_pkg::OP_ROR: begin
                t = {cin, it.mem[7:1]};
                reg_flags[cpu8_pkg::FLAG_C] = it.mem[0];
                we = 1; wa = it.ea; wd = set_zs(t);
            end
            cpu8_pkg::OP_CMP: t = sub_flags(reg_a, it.operand, 1'b0);
            cpu8_pkg::OP_CPX: t = sub_flags(reg_x, it.operand, 1'b0);
            cpu8_pkg::OP_CPY: t = sub_flags(reg_y, it.operand, 1'b0);
            cpu8_pkg::OP_JMP: cond = 1;
            cpu8_pkg::OP_JC: cond = c;
            cpu8_pkg::OP_JNC: cond = !c;
            cpu8_pkg::OP_JE: cond = z;
            cpu8_pkg::OP_JNE: cond = !z;
            cpu8_pkg::OP_JS: cond = s;
            cpu8_pkg::OP_JNS: cond = !s;
            cpu8_pkg::OP_JO: cond = v;
            cpu8_pkg::OP_JNO: cond = !v;
            cpu8_pkg::OP_JA: cond = !c && !z;
            cpu8_pkg::OP_JNA: cond = c || z;
            cpu8_pkg::OP_JL: cond = s != v;
            cpu8_pkg::OP_JGE: cond = s == v;
            cpu8_pkg::OP_JG: cond = !z && (s == v);
            cpu8_pkg::OP_JNG: cond = z || (s != v);
            cpu8_pkg::OP_LOOP: begin
                if (reg_y != 0) begin
                    reg_y = reg_y - 8'd1;
                    cond = 1;
                end
            end
            default: begin
                we = 1;
                wa = {reg_ss, reg_sp};
                wd = it.npc[15:8];
                reg_sp = reg_sp - 8'd1;
                wa2 = {reg_ss, reg_sp};
                wd2 = it.npc[7:0];
                reg_sp = reg_sp - 8'd1;
                cond = 1;
                n = 2;
            end
        endcase
        if (cond) npc = it.ea;
        for (int k = 0; k < n; k++) begin
            res.we = we;
            res.waddr = k ? wa2 : wa;
            res.wdata = k ? wd2 : wd;
            res.last = (k == n - 1);
            res.new_pc = npc;
            res.taken = cond;
            res.a = reg_a;
            res.x = reg_x;
            res.y = reg_y;
            res.flags = reg_flags;
            expected_outcomes.push_back(res);
        end
    endtask

    function automatic t_instr rand_instr(cpu8_pkg::t_op op);
        t_instr it;
        it.op = op;
        it.operand = $urandom_range(0, 9) == 0 ? 8'd0 : 8'($urandom);
        it.ea = 16'($urandom);
        it.mem = 8'($urandom);
        it.npc = 16'($urandom);
        return it;
    endfunction

    task automatic add_instr(cpu8_pkg::t_op op, logic [7:0] operand, logic [15:0] ea,
                             logic [7:0] mem, logic [15:0] npc);
        t_instr it;
        it.op = op;
        it.operand = operand;
        it.ea = ea;
        it.mem = mem;
        it.npc = npc;
        pending_instrs.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_instrs.size() != 0 || expected_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        t_instr it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_req_type <= '0;
            i_operand <= '0;
            i_effective_address <= '0;
            i_memory_value <= '0;
            i_next_pc <= '0;
        end else if (!i_valid || took) begin
            if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it = pending_instrs[0];
                i_valid <= 1'b1;
                i_req_type <= it.op;
                i_operand <= it.operand;
                i_effective_address <= it.ea;
                i_memory_value <= it.mem;
                i_next_pc <= it.npc;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // track acceptance and predict
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            execute_instr(pending_instrs.pop_front());
            took <= 1'b1;
        end else begin
            took <= 1'b0;
        end
    end

    initial begin
        wait (hold_req);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_off = 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_write_enable, o_write_address, o_write_data, o_last_result,
                    o_new_pc, o_branch_taken, o_acc_out, o_x_out, o_y_out, o_flags_out};
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_outcomes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        cpu8_pkg::t_op op;
        mismatches = 0;
        send_idle_pct = 17;
        recv_idle_pct = 45;
        {reg_a, reg_x, reg_y, reg_sp, reg_ss, reg_ds, reg_es} = '0;
        reg_flags = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_instr(cpu8_pkg::OP_LDA, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        add_instr(cpu8_pkg::OP_ADC, 8'h01, 16'h0000, 8'h00, 16'h0000);
        add_instr(cpu8_pkg::OP_LDA, 8'h80, 16'h1234, 8'h00, 16'h0001);
        add_instr(cpu8_pkg::OP_SBB, 8'h01, 16'h0000, 8'h00, 16'h0002);
        add_instr(cpu8_pkg::OP_DIV, 8'h00, 16'h0000, 8'h00, 16'h0003);
        add_instr(cpu8_pkg::OP_LDA, 8'h37, 16'h0000, 8'h00, 16'h0004);
        add_instr(cpu8_pkg::OP_MOD, 8'h00, 16'h0000, 8'h00, 16'h0005);
        add_instr(cpu8_pkg::OP_MUL, 8'hFF, 16'h0000, 8'h00, 16'h0006);
        add_instr(cpu8_pkg::OP_LDY, 8'h02, 16'h0000, 8'h00, 16'h0007);
        add_instr(cpu8_pkg::OP_LOOP, 8'h00, 16'hABCD, 8'h00, 16'h0008);
        add_instr(cpu8_pkg::OP_LOOP, 8'h00, 16'hABCD, 8'h00, 16'h0009);
        add_instr(cpu8_pkg::OP_LOOP, 8'h00, 16'hABCD, 8'h00, 16'h000A);
        add_instr(cpu8_pkg::OP_CALL, 8'h00, 16'hFFFF, 8'h00, 16'hA55A);
        add_instr(cpu8_pkg::OP_CALL, 8'h00, 16'h0000, 8'h00, 16'h0000);
        add_instr(cpu8_pkg::OP_ROL, 8'h00, 16'hFFFF, 8'hFF, 16'hFFFF);
        add_instr(cpu8_pkg::OP_ROR, 8'h00, 16'h0000, 8'h01, 16'h0000);
        add_instr(cpu8_pkg::OP_DEC, 8'h00, 16'h8000, 8'h00, 16'h0000);
        add_instr(cpu8_pkg::OP_CPX, 8'hFF, 16'h0000, 8'h00, 16'h0000);
        add_instr(cpu8_pkg::OP_JNG, 8'h00, 16'h5555, 8'h00, 16'hAAAA);
        for (int i = 0; i < 64; i++)
            pending_instrs.push_back(rand_instr(cpu8_pkg::t_op'(i)));
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 17 : phase == 1 ? 45 : 0;
            recv_idle_pct = phase == 0 ? 45 : phase == 1 ? 17 : 0;
            for (int i = 0; i < 400; i++) begin
                op = cpu8_pkg::t_op'($urandom_range(0, 63));
                pending_instrs.push_back(rand_instr(op));
            end
            if (phase == 2) hold_req = 1'b1;
            wait_drained();
        end
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
